/* rtl/core/seven_segment_scan_driver_core_macros.svh */
// assertion macros for the seven segment scan driver core
// no dependencies; taken in by the files that check their own logic
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_CORE_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_CORE_MACROS_SVH

// property holds at every edge outside reset
`define SSD_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SSD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ssd_pkg.sv */
// shared types, constants and the digit encoder of the seven segment scan driver
// no dependencies
package ssd_pkg;

  typedef struct packed {
    logic signed [15:0] display_value;
    logic               display_enable;
  } ssd_in_t;

  typedef struct packed {
    logic [3:0] anode_drive;
    logic [7:0] segment_drive;
    logic       updated;
  } ssd_out_t;

  localparam logic [7:0]  PRESCALE_RESET = 8'd2;
  localparam logic [1:0]  SCAN_FIRST     = 2'd3;
  localparam logic [3:0]  ANODES_OFF     = 4'hF;
  localparam logic [7:0]  SEG_BLANK      = 8'h00;
  localparam logic [7:0]  SEG_MINUS      = 8'h40;

  // shown range, exclusive bounds
  localparam logic signed [15:0] VALUE_ABOVE = 16'sd10000;
  localparam logic signed [15:0] VALUE_BELOW = -16'sd1000;

  // reciprocal multipliers, exact for magnitudes below 10000
  localparam logic [15:0] RECIP_10   = 16'd52429;
  localparam int          SHIFT_10   = 19;
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam int          SHIFT_100  = 19;
  localparam logic [13:0] RECIP_1000 = 14'd8389;
  localparam int          SHIFT_1000 = 23;

  localparam int MAG_W = 14;

  // scan positions
  localparam logic [1:0] POS_UNITS     = 2'd0;
  localparam logic [1:0] POS_TENS      = 2'd1;
  localparam logic [1:0] POS_HUNDREDS  = 2'd2;
  localparam logic [1:0] POS_THOUSANDS = 2'd3;

  function automatic logic [7:0] digit_segments(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

  // x * 10 as two shifted adds, in the magnitude width
  function automatic logic [MAG_W-1:0] times_ten(input logic [MAG_W-1:0] x);
    return MAG_W'({x, 3'b000}) + MAG_W'({x, 1'b0});
  endfunction

endpackage

/* rtl/core/seven_segment_scan_driver_core.sv */
// Four-digit seven segment scan driver.
// Input channel in_valid_i / in_stall_o / in_word_i: one word per timer tick with
// the value to show and an enable bit. Output channel out_valid_o / out_stall_i /
// out_word_o: one word per input word, carrying the active-low anodes, the
// segments a..g (decimal point always off) and an updated flag.
// A word is taken in at an edge where valid is high and stall is low.
// A word accepted into the input register passes on to the drive registers and
// is presented on the output from there.
// Throughput: one word per cycle while the receiver does not stall; the
// prescaler, the scan position and the digit extraction (three constant
// reciprocal multiplies) are combinational between the input and drive registers.
// The prescaler counts words down and on expiry reloads from the reload
// register (written via cfg_we_i / cfg_wdata_i) and rewrites the drive.
// Reset: reload and count 2, scan position 3, all anodes off, segments clear,
// both channels empty.
// While the receiver stalls the result word holds; if the input register is empty,
// one more input word is still taken into it, after which in_stall_o rises.
// Depends on ssd_pkg and seven_segment_scan_driver_core_macros.svh.
`include "seven_segment_scan_driver_core_macros.svh"

module seven_segment_scan_driver_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ssd_pkg::ssd_in_t  in_word_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ssd_pkg::ssd_out_t out_word_o
);
  import ssd_pkg::*;

  logic [7:0] prescale_reload_q;
  logic [7:0] prescale_cnt_q, prescale_cnt_d;
  logic [1:0] scan_q, scan_d;
  logic [3:0] held_anode_q, held_anode_d;
  logic [7:0] held_seg_q, held_seg_d;
  logic       upd_q;
  logic       in_vld_q;
  ssd_in_t    in_word_q;
  logic       out_vld_q;

  logic                   advance;
  logic                   load;
  logic                   expired;
  logic                   show;
  logic signed [15:0]     val;
  logic [15:0]            abs_val;
  logic [MAG_W-1:0]       mag;
  logic [29:0]            prod_10;
  logic [26:0]            prod_100;
  logic [27:0]            prod_1000;
  logic [MAG_W-1:0]       q10, q100, q1000;
  logic [3:0]             digit;
  logic [7:0]             seg_new;

  // output register free or draining this cycle
  assign advance    = !out_vld_q || !out_stall_i;
  assign load       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;

  assign val     = in_word_q.display_value;
  assign abs_val = val[15] ? 16'(-val) : 16'(val);
  assign mag     = abs_val[MAG_W-1:0];
  assign show    = in_word_q.display_enable && (val < VALUE_ABOVE) && (val > VALUE_BELOW);
  assign expired = (prescale_cnt_q <= 8'd1);

  assign prod_10   = 30'(mag) * 30'(RECIP_10);
  assign prod_100  = 27'(mag) * 27'(RECIP_100);
  assign prod_1000 = 28'(mag) * 28'(RECIP_1000);
  assign q10       = MAG_W'(prod_10 >> SHIFT_10);
  assign q100      = MAG_W'(prod_100 >> SHIFT_100);
  assign q1000     = MAG_W'(prod_1000 >> SHIFT_1000);

  always_comb begin
    case (scan_q)
      POS_UNITS:     digit = 4'(mag - times_ten(q10));
      POS_TENS:      digit = 4'(q10 - times_ten(q100));
      POS_HUNDREDS:  digit = 4'(q100 - times_ten(q1000));
      POS_THOUSANDS: digit = 4'(q1000);
      default:       digit = 4'd0;
    endcase
    if (scan_q == POS_THOUSANDS && val[15]) begin
      seg_new = SEG_MINUS;
    end else begin
      seg_new = digit_segments(digit);
    end
  end

  always_comb begin
    prescale_cnt_d = prescale_cnt_q;
    scan_d         = scan_q;
    held_anode_d   = held_anode_q;
    held_seg_d     = held_seg_q;
    if (expired) begin
      prescale_cnt_d = prescale_reload_q;
      if (show) begin
        held_seg_d   = seg_new;
        held_anode_d = ANODES_OFF & ~(4'b0001 << scan_q);
        scan_d       = scan_q - 2'd1;
      end else begin
        held_anode_d = ANODES_OFF;
        held_seg_d   = SEG_BLANK;
      end
    end else begin
      prescale_cnt_d = prescale_cnt_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_reload_q <= PRESCALE_RESET;
    end else if (cfg_we_i) begin
      prescale_reload_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // word register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q      <= 1'b0;
      upd_q          <= 1'b0;
      prescale_cnt_q <= PRESCALE_RESET;
      scan_q         <= SCAN_FIRST;
      held_anode_q   <= ANODES_OFF;
      held_seg_q     <= SEG_BLANK;
    end else begin
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
      if (load) begin
        upd_q          <= expired;
        prescale_cnt_q <= prescale_cnt_d;
        scan_q         <= scan_d;
        held_anode_q   <= held_anode_d;
        held_seg_q     <= held_seg_d;
      end
    end
  end

  // the held drive state is the result register
  assign out_valid_o              = out_vld_q;
  assign out_word_o.anode_drive   = held_anode_q;
  assign out_word_o.segment_drive = held_seg_q;
  assign out_word_o.updated       = upd_q;

  `SSD_ASSERT_ALWAYS(a_one_anode, clk_i, rst_ni, $onehot0(~held_anode_q), "more than one anode low")
  `SSD_ASSERT_IMPLIES(a_blank_dark, clk_i, rst_ni, held_anode_q == ANODES_OFF, held_seg_q == SEG_BLANK, "segments lit with anodes off")
  `SSD_ASSERT_NEXT(a_hold_drive, clk_i, rst_ni, load && !expired, $stable(held_anode_q) && $stable(held_seg_q), "drive changed without expiry")
  `SSD_ASSERT_NEXT(a_scan_step, clk_i, rst_ni, load && expired && show, scan_q == $past(scan_q) - 2'd1, "scan position did not step")
  `SSD_ASSERT_IMPLIES(a_stall_full, clk_i, rst_ni, in_stall_o, in_vld_q && out_vld_q, "stall with a free stage")

endmodule

/* tb/tb.sv */
// self-checking testbench for seven_segment_scan_driver_core
// keeps its own prediction of the prescaler, scan position and held drive
// depends on ssd_pkg and the core
`timescale 1ns / 100ps

module tb;
  import ssd_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int RUN_LIMIT   = 20_000_000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  ssd_in_t    in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  ssd_out_t   out_word;

  // predicted state of the block
  logic [7:0] pred_reload;
  logic [7:0] pred_count;
  logic [1:0] pred_scan;
  logic [3:0] pred_anodes;
  logic [7:0] pred_segments;

  ssd_out_t expected_drive[$];
  int       errors = 0;

  // sender bursts and gaps
  int gap_max = 0;
  int burst_left = 0;

  // receiver stall pattern
  int   stall_pct = 0;
  int   hold_trig = 0;
  int   hold_ack = 0;
  int   hold_left = 0;
  int   run_left = 0;
  logic run_level = 1'b0;

  seven_segment_scan_driver_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("FAIL");
    $finish;
  end

  function automatic logic [7:0] digit_pattern(input int digit);
    logic [7:0] seg;
    case (digit)
      0:       seg = 8'h3F;
      1:       seg = 8'h06;
      2:       seg = 8'h5B;
      3:       seg = 8'h4F;
      4:       seg = 8'h66;
      5:       seg = 8'h6D;
      6:       seg = 8'h7D;
      7:       seg = 8'h07;
      8:       seg = 8'h7F;
      default: seg = 8'h6F;
    endcase
    return seg;
  endfunction

  function automatic ssd_in_t make_tick(input int value, input logic enable);
    ssd_in_t w;
    w.display_value  = value[15:0];
    w.display_enable = enable;
    return w;
  endfunction

  // one accepted tick: advance the prescaler and the drive, queue the result
  task automatic predict_tick(input ssd_in_t w);
    int       v;
    int       mag;
    logic     expired;
    ssd_out_t res;
    begin
      v = int'(w.display_value);
      mag = (v < 0) ? -v : v;
      expired = (pred_count <= 8'd1);
      if (expired) begin
        pred_count = pred_reload;
        if (w.display_enable && v < 10000 && v > -1000) begin
          case (pred_scan)
            POS_UNITS:    pred_segments = digit_pattern(mag % 10);
            POS_TENS:     pred_segments = digit_pattern((mag % 100) / 10);
            POS_HUNDREDS: pred_segments = digit_pattern((mag % 1000) / 100);
            default: begin
              if (v < 0) pred_segments = SEG_MINUS;
              else pred_segments = digit_pattern(mag / 1000);
            end
          endcase
          pred_anodes = ANODES_OFF & ~(4'b0001 << pred_scan);
          pred_scan = pred_scan - 2'd1;
        end else begin
          pred_anodes = ANODES_OFF;
          pred_segments = SEG_BLANK;
        end
      end else begin
        pred_count = pred_count - 8'd1;
      end
      res.anode_drive = pred_anodes;
      res.segment_drive = pred_segments;
      res.updated = expired;
      expected_drive.push_back(res);
    end
  endtask

  // offer one word, wait for it to be taken, then maybe end the burst
  task automatic send_tick(input ssd_in_t w);
    int gap;
    begin
      in_valid <= 1'b1;
      in_word <= w;
      do @(posedge clk); while (in_stall);
      predict_tick(w);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
  endtask

  task automatic await_drained();
    begin
      in_valid <= 1'b0;
      while (expected_drive.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_reload(input logic [7:0] value);
    begin
      await_drained();
      cfg_we <= 1'b1;
      cfg_wdata <= value;
      @(posedge clk);
      cfg_we <= 1'b0;
      pred_reload = value;
    end
  endtask

  function automatic int random_value();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = int'($urandom_range(0, 10998)) - 999;
      6: v = int'($urandom_range(0, 1998)) - 999;
      7: begin
        case ($urandom_range(0, 5))
          0:       v = 9999;
          1:       v = 10000;
          2:       v = -999;
          3:       v = -1000;
          4:       v = 0;
          default: v = -1;
        endcase
      end
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return v;
  endfunction

  task automatic send_random(input int count);
    begin
      repeat (count) send_tick(make_tick(random_value(), $urandom_range(0, 9) != 0));
    end
  endtask

  // receiver: random stall runs, plus a long counted hold on request
  always @(posedge clk) begin
    if (hold_trig != hold_ack) begin
      hold_ack = hold_trig;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 8);
        run_level = ($urandom_range(0, 99) < stall_pct);
      end
      run_left--;
      out_stall <= run_level;
    end
  end

  // result check against the oldest expected word
  always @(posedge clk) begin
    ssd_out_t exp_word;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_drive.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, got %h", $time, out_word);
      end else begin
        exp_word = expected_drive.pop_front();
        if (out_word.anode_drive !== exp_word.anode_drive) begin
          errors++;
          $display("%0t: anode_drive expected %h got %h", $time,
                   exp_word.anode_drive, out_word.anode_drive);
        end
        if (out_word.segment_drive !== exp_word.segment_drive) begin
          errors++;
          $display("%0t: segment_drive expected %h got %h", $time,
                   exp_word.segment_drive, out_word.segment_drive);
        end
        if (out_word.updated !== exp_word.updated) begin
          errors++;
          $display("%0t: updated expected %b got %b", $time,
                   exp_word.updated, out_word.updated);
        end
      end
    end
  end

  // reset setting: field extremes, blanking and out of range values
  task automatic test_reset_setting();
    begin
      gap_max = 2;
      stall_pct = 20;
      send_tick(make_tick(0, 1'b1));
      send_tick(make_tick(9999, 1'b1));
      send_tick(make_tick(-999, 1'b1));
      send_tick(make_tick(-1, 1'b1));
      send_tick(make_tick(10000, 1'b1));
      send_tick(make_tick(-1000, 1'b1));
      send_tick(make_tick(32767, 1'b1));
      send_tick(make_tick(-32768, 1'b1));
      send_tick(make_tick(5678, 1'b0));
      send_tick(make_tick(1234, 1'b1));
      send_tick(make_tick(1234, 1'b1));
      send_tick(make_tick(1234, 1'b1));
    end
  endtask

  // zero reload expires on every tick; reload of one likewise
  task automatic test_fast_reload();
    begin
      write_reload(8'd0);
      repeat (4) send_tick(make_tick(-999, 1'b1));
      repeat (4) send_tick(make_tick(8051, 1'b1));
      write_reload(8'd1);
      repeat (4) send_tick(make_tick(-42, 1'b1));
    end
  endtask

  task automatic test_random_settings();
    logic [7:0] reloads [5];
    begin
      reloads[0] = 8'd1;
      reloads[1] = 8'd255;
      reloads[2] = 8'd0;
      reloads[3] = 8'd3;
      reloads[4] = 8'($urandom_range(1, 255));
      for (int i = 0; i < 5; i++) begin
        write_reload(reloads[i]);
        gap_max = (i == 2) ? 0 : 6;
        stall_pct = (i == 3) ? 0 : 35;
        send_random(200);
      end
    end
  endtask

  // receiver holds off while the sender keeps offering, then a full pause
  task automatic test_backpressure();
    begin
      write_reload(8'd2);
      gap_max = 0;
      stall_pct = 25;
      hold_trig++;
      send_random(60);
      await_drained();
      gap_max = 4;
      send_random(20);
    end
  endtask

  initial begin
    pred_reload = PRESCALE_RESET;
    pred_count = PRESCALE_RESET;
    pred_scan = SCAN_FIRST;
    pred_anodes = ANODES_OFF;
    pred_segments = SEG_BLANK;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_setting();
    test_fast_reload();
    test_random_settings();
    test_backpressure();

    await_drained();
    repeat (4) @(posedge clk);
    if (errors == 0 && expected_drive.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
